FILE: sv/sot_pkg.sv
// Shared types and constants for the segment offset translator.
// Used by sot_ctrl, sot_dp and segment_offset_translator; no dependencies.
`default_nettype none
package sot_pkg;

  localparam int DEF_MAX_SEGMENTS = 128;

  localparam int OFF_W    = 32;
  localparam int LEN_W    = 32;
  localparam int BASE_W   = 64;
  localparam int SLOT_W   = 7;
  localparam int KIND_W   = 4;
  localparam int CNT_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int ENTRY_W  = BASE_W + LEN_W + OFF_W;

  localparam logic [KIND_W-1:0] KIND_NULL    = 4'd0;
  localparam logic [KIND_W-1:0] KIND_VIRTUAL = 4'd5;

  localparam logic ACT_LOAD      = 1'b0;
  localparam logic ACT_TRANSLATE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_VIRTUAL_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYSICAL_COUNT = 1'd1;

  typedef enum logic [1:0] {
    ST_FOUND  = 2'd0,
    ST_NULL   = 2'd1,
    ST_MISS   = 2'd2,
    ST_LOADED = 2'd3
  } status_e;

  typedef struct packed {
    logic    latch;
    logic    load_wr;
    logic    scan_init;
    logic    scan_step;
    logic    hit_take;
    logic    add;
    logic    set_st;
    status_e st;
    logic    put;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_null;
    logic hit;
    logic miss;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: sv/sot_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: sv/sot_ctrl.sv
// Controller state machine of the segment offset translator.
// Depends on sot_pkg for the command and status structs.
`default_nettype none
module sot_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire sot_pkg::sts_t sts_i,
  output      sot_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_ADD,
    S_PUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.st      = sot_pkg::ST_FOUND;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_load) begin
          cmd_o.load_wr = 1'b1;
          cmd_o.set_st  = 1'b1;
          cmd_o.st      = sot_pkg::ST_LOADED;
          state_d       = S_PUT;
        end else if (sts_i.is_null) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = sot_pkg::ST_NULL;
          state_d      = S_PUT;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          cmd_o.hit_take = 1'b1;
          state_d        = S_ADD;
        end else if (sts_i.miss) begin
          cmd_o.set_st = 1'b1;
          cmd_o.st     = sot_pkg::ST_MISS;
          state_d      = S_PUT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_ADD: begin
        cmd_o.add    = 1'b1;
        cmd_o.set_st = 1'b1;
        cmd_o.st     = sot_pkg::ST_FOUND;
        state_d      = S_PUT;
      end
      S_PUT: begin
        if (sts_i.out_free) begin
          cmd_o.put = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: sv/sot_dp.sv
// Datapath of the segment offset translator: item latch, count registers,
// segment table RAM, scan pointer, range check, address add and result word.
// Depends on sot_pkg and sot_ram.
`default_nettype none
module sot_dp #(
  parameter int MAX_SEGMENTS = sot_pkg::DEF_MAX_SEGMENTS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [sot_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [sot_pkg::CNT_W-1:0]       cfg_data_i,
  input  wire logic                            action_i,
  input  wire logic [sot_pkg::SLOT_W-1:0]      entry_index_i,
  input  wire logic [sot_pkg::OFF_W-1:0]       entry_offset_i,
  input  wire logic [sot_pkg::LEN_W-1:0]       entry_length_i,
  input  wire logic [sot_pkg::BASE_W-1:0]      entry_base_i,
  input  wire logic [sot_pkg::KIND_W-1:0]      segment_kind_i,
  input  wire logic [sot_pkg::OFF_W-1:0]       file_offset_i,
  output      logic                            out_valid_o,
  input  wire logic                            out_ready_i,
  output      logic [sot_pkg::BASE_W-1:0]      address_o,
  output      logic [sot_pkg::SLOT_W-1:0]      hit_index_o,
  output      logic [1:0]                      status_o,
  input  wire sot_pkg::cmd_t                   cmd_i,
  output      sot_pkg::sts_t                   sts_o
);

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int BW    = (IDX_W + 1 > sot_pkg::CNT_W + 1) ? IDX_W + 1 : sot_pkg::CNT_W + 1;
  localparam logic [BW-1:0] MaxSeg = BW'(MAX_SEGMENTS);

  logic [sot_pkg::CNT_W-1:0]  vcount_q, pcount_q;

  logic                       action_q;
  logic [sot_pkg::SLOT_W-1:0] slot_q;
  logic [sot_pkg::OFF_W-1:0]  eoff_q;
  logic [sot_pkg::LEN_W-1:0]  elen_q;
  logic [sot_pkg::BASE_W-1:0] ebase_q;
  logic [sot_pkg::KIND_W-1:0] kind_q;
  logic [sot_pkg::OFF_W-1:0]  foff_q;

  logic [BW-1:0]              ptr_q, last_q;
  logic [BW-1:0]              first_d, sum_d, last_d;
  logic                       rd_v_q;
  logic [IDX_W-1:0]           rd_idx_q;
  logic                       issue;

  logic [sot_pkg::ENTRY_W-1:0] rdata;
  logic [sot_pkg::OFF_W-1:0]   r_start;
  logic [sot_pkg::LEN_W-1:0]   r_len;
  logic [sot_pkg::BASE_W-1:0]  r_base;
  logic [sot_pkg::OFF_W:0]     r_end;
  logic                        match;
  logic                        wr_ok;

  logic [sot_pkg::BASE_W-1:0]  hbase_q;
  logic [sot_pkg::OFF_W-1:0]   diff_q;
  logic [IDX_W-1:0]            hidx_q;
  logic [sot_pkg::BASE_W-1:0]  addr_q;
  sot_pkg::status_e            res_st_q;

  logic                        out_valid_q;
  logic [sot_pkg::BASE_W-1:0]  out_addr_q;
  logic [sot_pkg::SLOT_W-1:0]  out_hit_q;
  sot_pkg::status_e            out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
      pcount_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sot_pkg::CFG_VIRTUAL_COUNT:  vcount_q <= cfg_data_i;
        sot_pkg::CFG_PHYSICAL_COUNT: pcount_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      action_q <= action_i;
      slot_q   <= entry_index_i;
      eoff_q   <= entry_offset_i;
      elen_q   <= entry_length_i;
      ebase_q  <= entry_base_i;
      kind_q   <= segment_kind_i;
      foff_q   <= file_offset_i;
    end
  end

  assign sum_d   = BW'(vcount_q) + BW'(pcount_q);
  assign first_d = (kind_q == sot_pkg::KIND_VIRTUAL) ? '0 : BW'(vcount_q);
  always_comb begin
    last_d = (kind_q == sot_pkg::KIND_VIRTUAL) ? BW'(vcount_q) : sum_d;
    if (last_d > MaxSeg) begin
      last_d = MaxSeg;
    end
  end

  assign issue = cmd_i.scan_step && (ptr_q < last_q);
  assign wr_ok = (32'(slot_q) < 32'(MAX_SEGMENTS));

  sot_ram #(
    .WIDTH(sot_pkg::ENTRY_W),
    .DEPTH(MAX_SEGMENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_wr && wr_ok),
    .waddr_i (IDX_W'(slot_q)),
    .wdata_i ({ebase_q, elen_q, eoff_q}),
    .re_i    (issue),
    .raddr_i (ptr_q[IDX_W-1:0]),
    .rdata_o (rdata)
  );

  assign r_start = rdata[sot_pkg::OFF_W-1:0];
  assign r_len   = rdata[sot_pkg::OFF_W +: sot_pkg::LEN_W];
  assign r_base  = rdata[sot_pkg::OFF_W + sot_pkg::LEN_W +: sot_pkg::BASE_W];
  assign r_end   = {1'b0, r_start} + {1'b0, r_len};
  assign match   = (foff_q >= r_start) && ({1'b0, foff_q} < r_end);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      ptr_q  <= first_d;
      last_q <= last_d;
    end else if (issue) begin
      ptr_q <= ptr_q + BW'(1);
    end
    if (issue) begin
      rd_idx_q <= ptr_q[IDX_W-1:0];
    end
    if (cmd_i.hit_take) begin
      hbase_q <= r_base;
      diff_q  <= foff_q - r_start;
      hidx_q  <= rd_idx_q;
    end
    if (cmd_i.add) begin
      addr_q <= hbase_q + sot_pkg::BASE_W'(diff_q);
    end
    if (cmd_i.set_st) begin
      res_st_q <= cmd_i.st;
    end
    if (cmd_i.put) begin
      out_st_q   <= res_st_q;
      out_addr_q <= (res_st_q == sot_pkg::ST_FOUND) ? addr_q : '0;
      out_hit_q  <= (res_st_q == sot_pkg::ST_FOUND) ? sot_pkg::SLOT_W'(hidx_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.put) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.is_load  = (action_q == sot_pkg::ACT_LOAD);
  assign sts_o.is_null  = (kind_q == sot_pkg::KIND_NULL);
  assign sts_o.hit      = rd_v_q && match;
  assign sts_o.miss     = !rd_v_q && !(ptr_q < last_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign address_o   = out_addr_q;
  assign hit_index_o = out_hit_q;
  assign status_o    = out_st_q;

endmodule
`default_nettype wire

FILE: sv/segment_offset_translator.sv
// Segment offset translator, one item at a time: load and null-kind items go from decode
// straight to the result word; a translate scans its range of at most MAX_SEGMENTS
// entries, one RAM read a cycle, then adds the base (an empty range is a miss).
// The next input word is accepted in the cycle after the result word is registered,
// even while that word still waits in the output register.
// Reset clears the counts and control state; table entries hold no reset value.
`default_nettype none
module segment_offset_translator #(
  parameter int MAX_SEGMENTS = sot_pkg::DEF_MAX_SEGMENTS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [sot_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [sot_pkg::CNT_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic                          action_i,
  input  wire logic [sot_pkg::SLOT_W-1:0]    entry_index_i,
  input  wire logic [sot_pkg::OFF_W-1:0]     entry_offset_i,
  input  wire logic [sot_pkg::LEN_W-1:0]     entry_length_i,
  input  wire logic [sot_pkg::BASE_W-1:0]    entry_base_i,
  input  wire logic [sot_pkg::KIND_W-1:0]    segment_kind_i,
  input  wire logic [sot_pkg::OFF_W-1:0]     file_offset_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [sot_pkg::BASE_W-1:0]    address_o,
  output      logic [sot_pkg::SLOT_W-1:0]    hit_index_o,
  output      logic [1:0]                    status_o
);

  sot_pkg::cmd_t cmd;
  sot_pkg::sts_t sts;

  sot_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sot_dp #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .entry_index_i  (entry_index_i),
    .entry_offset_i (entry_offset_i),
    .entry_length_i (entry_length_i),
    .entry_base_i   (entry_base_i),
    .segment_kind_i (segment_kind_i),
    .file_offset_i  (file_offset_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .address_o      (address_o),
    .hit_index_o    (hit_index_o),
    .status_o       (status_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Testbench for segment_offset_translator: directed table, then random loads and lookups.
// Depends on sot_pkg and the RTL only. Each result word is checked against a fixed
// expected word or against a behavioral segment table kept in this file.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_W    = sot_pkg::SLOT_W;
  localparam int OFF_W     = sot_pkg::OFF_W;
  localparam int LEN_W     = sot_pkg::LEN_W;
  localparam int BASE_W    = sot_pkg::BASE_W;
  localparam int KIND_W    = sot_pkg::KIND_W;
  localparam int CNT_W     = sot_pkg::CNT_W;
  localparam int CFG_IDX_W = sot_pkg::CFG_IDX_W;

  localparam logic [KIND_W-1:0]    KIND_NULL          = sot_pkg::KIND_NULL;
  localparam logic [KIND_W-1:0]    KIND_VIRTUAL       = sot_pkg::KIND_VIRTUAL;
  localparam logic                 ACT_LOAD           = sot_pkg::ACT_LOAD;
  localparam logic                 ACT_TRANSLATE      = sot_pkg::ACT_TRANSLATE;
  localparam logic [CFG_IDX_W-1:0] CFG_VIRTUAL_COUNT  = sot_pkg::CFG_VIRTUAL_COUNT;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYSICAL_COUNT = sot_pkg::CFG_PHYSICAL_COUNT;

  typedef sot_pkg::status_e status_e;
  localparam status_e ST_FOUND  = sot_pkg::ST_FOUND;
  localparam status_e ST_NULL   = sot_pkg::ST_NULL;
  localparam status_e ST_MISS   = sot_pkg::ST_MISS;
  localparam status_e ST_LOADED = sot_pkg::ST_LOADED;

  localparam int TABLE_DEPTH = sot_pkg::DEF_MAX_SEGMENTS;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PLAN_DEPTH  = 32;
  localparam int FIFO_DEPTH  = 16;

  typedef struct packed {
    logic              action;
    logic [SLOT_W-1:0] slot;
    logic [OFF_W-1:0]  start;
    logic [LEN_W-1:0]  len;
    logic [BASE_W-1:0] base;
    logic [KIND_W-1:0] kind;
    logic [OFF_W-1:0]  offset;
  } word_t;

  typedef struct {
    logic [BASE_W-1:0] address;
    logic [SLOT_W-1:0] hit;
    status_e           status;
  } result_t;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct {
    row_kind_e        what;
    word_t            w;
    bit               fixed;
    result_t          want;
    logic [CNT_W-1:0] vcnt;
    logic [CNT_W-1:0] pcnt;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CNT_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 action_i = 1'b0;
  logic [SLOT_W-1:0]    entry_index_i = '0;
  logic [OFF_W-1:0]     entry_offset_i = '0;
  logic [LEN_W-1:0]     entry_length_i = '0;
  logic [BASE_W-1:0]    entry_base_i = '0;
  logic [KIND_W-1:0]    segment_kind_i = '0;
  logic [OFF_W-1:0]     file_offset_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [BASE_W-1:0]    address_o;
  logic [SLOT_W-1:0]    hit_index_o;
  logic [1:0]           status_o;

  segment_offset_translator dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .action_i, .entry_index_i, .entry_offset_i,
    .entry_length_i, .entry_base_i, .segment_kind_i, .file_offset_i,
    .out_valid_o, .out_ready_i, .address_o, .hit_index_o, .status_o
  );

  always #6 clk_i = ~clk_i;

  logic [OFF_W-1:0]  tbl_start [TABLE_DEPTH];
  logic [LEN_W-1:0]  tbl_len [TABLE_DEPTH];
  logic [BASE_W-1:0] tbl_base [TABLE_DEPTH];
  int unsigned       num_virtual = 0;
  int unsigned       num_physical = 0;

  result_t     result_fifo [FIFO_DEPTH];
  int unsigned fifo_wr = 0;
  int unsigned fifo_rd = 0;
  row_t        plan [PLAN_DEPTH];
  int unsigned plan_len = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned gap_pct = 20;
  int unsigned stall_pct = 20;
  int unsigned stall_left = 0;

  function automatic result_t mk_result(logic [BASE_W-1:0] addr, logic [SLOT_W-1:0] hit,
                                        status_e st);
    result_t r;
    r.address = addr;
    r.hit = hit;
    r.status = st;
    return r;
  endfunction

  function automatic void search_range(logic [KIND_W-1:0] kind, output int unsigned first,
                                       output int unsigned last);
    if (kind == KIND_VIRTUAL) begin
      first = 0;
      last = num_virtual;
    end else begin
      first = num_virtual;
      last = num_virtual + num_physical;
    end
    if (last > TABLE_DEPTH) last = TABLE_DEPTH;
  endfunction

  // Apply one word to the segment table and return the word it yields.
  function automatic result_t translate_word(word_t w);
    result_t     r;
    int unsigned first, last;
    logic [32:0] lo, hi;
    bit          found;
    r = mk_result('0, '0, ST_MISS);
    found = 1'b0;
    if (w.action == ACT_LOAD) begin
      tbl_start[w.slot] = w.start;
      tbl_len[w.slot] = w.len;
      tbl_base[w.slot] = w.base;
      r.status = ST_LOADED;
    end else if (w.kind == KIND_NULL) begin
      r.status = ST_NULL;
    end else begin
      search_range(w.kind, first, last);
      for (int unsigned i = first; i < last && !found; i++) begin
        lo = {1'b0, tbl_start[i]};
        hi = lo + {1'b0, tbl_len[i]};
        if ({1'b0, w.offset} >= lo && {1'b0, w.offset} < hi) begin
          found = 1'b1;
          r = mk_result(tbl_base[i] + {32'b0, w.offset - tbl_start[i]}, SLOT_W'(i), ST_FOUND);
        end
      end
    end
    return r;
  endfunction

  function automatic word_t rand_noise();
    word_t w;
    w.action = 1'($urandom);
    w.slot = SLOT_W'($urandom);
    w.start = $urandom;
    w.len = $urandom;
    w.base = {$urandom, $urandom};
    w.kind = KIND_W'($urandom);
    w.offset = $urandom;
    return w;
  endfunction

  function automatic word_t rand_entry(logic [SLOT_W-1:0] slot);
    word_t       w;
    int unsigned pick;
    w = rand_noise();
    w.action = ACT_LOAD;
    w.slot = slot;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.start = $urandom_range(0, 'h3FF);
      w.len = $urandom_range(1, 'h400);
    end else if (pick < 65) begin
      w.start = $urandom;
      w.len = $urandom;
    end else if (pick < 80) begin
      w.start = 32'hFFFF_FFFF - $urandom_range(0, 'hFFF);
      w.len = $urandom_range('h800, 32'hFFFF_FFFF);
    end else if (pick < 90) begin
      w.len = '0;
    end else begin
      w.start = $urandom_range(0, 'hFF);
      w.len = 32'hFFFF_FFFF - $urandom_range(0, 'hFF);
    end
    if ($urandom_range(0, 9) == 0) w.base = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 'hFFFF);
    return w;
  endfunction

  // Aim most lookups inside, or right at the edge of, an entry of the searched range.
  function automatic word_t rand_lookup();
    word_t           w;
    int unsigned     pick, first, last, e;
    logic [32:0]     hi;
    longint unsigned room;
    w = rand_noise();
    w.action = ACT_TRANSLATE;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      w.kind = KIND_NULL;
    end else if (pick < 54) begin
      w.kind = KIND_VIRTUAL;
    end else begin
      w.kind = KIND_W'($urandom_range(1, 14));
      if (w.kind >= KIND_VIRTUAL) w.kind = w.kind + 1'b1;
    end
    search_range(w.kind, first, last);
    pick = $urandom_range(0, 99);
    if (w.kind != KIND_NULL && last > first && pick < 80) begin
      e = $urandom_range(first, last - 1);
      hi = {1'b0, tbl_start[e]} + {1'b0, tbl_len[e]};
      if (pick < 65 && tbl_len[e] != 0) begin
        room = 64'h1_0000_0000 - tbl_start[e];
        if (tbl_len[e] < room) room = tbl_len[e];
        w.offset = tbl_start[e] + OFF_W'($urandom % room);
      end else if (!hi[32]) begin
        w.offset = hi[31:0];
      end else begin
        w.offset = tbl_start[e] - 1'b1;
      end
    end
    return w;
  endfunction

  function automatic void add_row(row_t r);
    plan[plan_len] = r;
    plan_len++;
  endfunction

  function automatic void add_load(logic [SLOT_W-1:0] slot, logic [OFF_W-1:0] start,
                                   logic [LEN_W-1:0] len, logic [BASE_W-1:0] base);
    row_t r;
    r.what = ROW_WORD;
    r.w = rand_noise();
    r.w.action = ACT_LOAD;
    r.w.slot = slot;
    r.w.start = start;
    r.w.len = len;
    r.w.base = base;
    r.fixed = 1'b1;
    r.want = mk_result('0, '0, ST_LOADED);
    add_row(r);
  endfunction

  function automatic void add_lookup(logic [KIND_W-1:0] kind, logic [OFF_W-1:0] offset,
                                     bit fixed, logic [BASE_W-1:0] addr,
                                     logic [SLOT_W-1:0] hit, status_e st);
    row_t r;
    r.what = ROW_WORD;
    r.w = rand_noise();
    r.w.action = ACT_TRANSLATE;
    r.w.kind = kind;
    r.w.offset = offset;
    r.fixed = fixed;
    r.want = mk_result(addr, hit, st);
    add_row(r);
  endfunction

  function automatic void add_cfg(logic [CNT_W-1:0] v, logic [CNT_W-1:0] p);
    row_t r;
    r.what = ROW_CFG;
    r.vcnt = v;
    r.pcnt = p;
    add_row(r);
  endfunction

  task automatic send_word(input word_t w, input bit fixed, input result_t want);
    result_t r;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= w.action;
    entry_index_i <= w.slot;
    entry_offset_i <= w.start;
    entry_length_i <= w.len;
    entry_base_i <= w.base;
    segment_kind_i <= w.kind;
    file_offset_i <= w.offset;
    do @(posedge clk_i); while (!in_ready_o);
    r = translate_word(w);
    if (fixed) result_fifo[fifo_wr % FIFO_DEPTH] = want;
    else result_fifo[fifo_wr % FIFO_DEPTH] = r;
    fifo_wr++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (fifo_rd == fifo_wr);
    @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    if (idx == CFG_VIRTUAL_COUNT) num_virtual = value;
    else num_physical = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_counts(input logic [CNT_W-1:0] v, input logic [CNT_W-1:0] p);
    drain();
    write_cfg(CFG_VIRTUAL_COUNT, v);
    write_cfg(CFG_PHYSICAL_COUNT, p);
  endtask

  task automatic run_phase(input int unsigned v, input int unsigned p, input int unsigned gap,
                           input int unsigned stall, input int unsigned n);
    word_t w;
    set_counts(CNT_W'(v), CNT_W'(p));
    gap_pct = gap;
    stall_pct = stall;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 2) drain();
      if ($urandom_range(0, 99) < 15) w = rand_entry(SLOT_W'($urandom));
      else w = rand_lookup();
      send_word(w, 1'b0, mk_result('0, '0, ST_FOUND));
    end
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (fifo_rd == fifo_wr) begin
        $error("result word with nothing pending: address %h status %0d", address_o, status_o);
        mismatches++;
      end else begin
        want = result_fifo[fifo_rd % FIFO_DEPTH];
        fifo_rd++;
        if (address_o !== want.address) begin
          $error("address: expected %h, got %h", want.address, address_o);
          mismatches++;
        end
        if (hit_index_o !== want.hit) begin
          $error("hit_index: expected %0d, got %0d", want.hit, hit_index_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
      end
    end
    if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    // Counts are zero after reset, so every search starts out empty.
    add_lookup(KIND_NULL, '0, 1'b1, '0, '0, ST_NULL);
    add_lookup(KIND_VIRTUAL, '0, 1'b1, '0, '0, ST_MISS);
    add_lookup(4'hF, 32'hFFFF_FFFF, 1'b1, '0, '0, ST_MISS);
    add_load(7'd0, 32'h0, 32'h10, 64'h0);
    add_load(7'd1, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF8);
    add_load(7'd2, 32'h0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_load(7'd3, 32'h8, 32'h100, 64'h1000);
    add_load(7'd127, 32'h20, 32'h20, 64'h1234);
    add_cfg(8'd2, 8'd2);
    add_lookup(KIND_VIRTUAL, 32'h0, 1'b1, 64'h0, 7'd0, ST_FOUND);
    add_lookup(KIND_VIRTUAL, 32'hF, 1'b1, 64'hF, 7'd0, ST_FOUND);
    add_lookup(KIND_VIRTUAL, 32'h10, 1'b1, '0, '0, ST_MISS);
    add_lookup(KIND_VIRTUAL, 32'hFFFF_FFFF, 1'b0, '0, '0, ST_FOUND);
    add_lookup(KIND_VIRTUAL, 32'hFFFF_FFF0, 1'b0, '0, '0, ST_FOUND);
    add_lookup(4'd3, 32'h8, 1'b0, '0, '0, ST_FOUND);
    add_lookup(4'd10, 32'h0, 1'b1, '0, '0, ST_MISS);
    add_lookup(KIND_NULL, 32'h8, 1'b1, '0, '0, ST_NULL);
    add_lookup(4'hF, 32'h107, 1'b0, '0, '0, ST_FOUND);
    add_cfg(8'd2, 8'd0);
    add_lookup(4'd3, 32'h8, 1'b1, '0, '0, ST_MISS);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned i = 0; i < plan_len; i++) begin
      if (plan[i].what == ROW_CFG) set_counts(plan[i].vcnt, plan[i].pcnt);
      else send_word(plan[i].w, plan[i].fixed, plan[i].want);
    end

    // Fill the whole table before any wider search.
    for (int unsigned s = 0; s < TABLE_DEPTH; s++)
      send_word(rand_entry(SLOT_W'(s)), 1'b0, mk_result('0, '0, ST_FOUND));

    run_phase(128, 0, 20, 20, 135);
    run_phase(0, 128, 0, 0, 135);
    run_phase(128, 128, 30, 30, 135);
    run_phase(64, 64, 10, 40, 135);
    run_phase(100, 100, 40, 10, 135);
    run_phase(1, 127, 20, 20, 135);
    run_phase(0, 0, 20, 20, 60);
    run_phase($urandom_range(0, 128), $urandom_range(0, 128), 25, 25, 135);
    run_phase($urandom_range(0, 128), $urandom_range(0, 128), 15, 35, 135);
    run_phase(40, 88, 0, 0, 135);

    drain();
    repeat (150) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
sv/sot_pkg.sv
sv/sot_ram.sv
sv/sot_ctrl.sv
sv/sot_dp.sv
sv/segment_offset_translator.sv
tb/testbench.sv
